FILE: rtl/quaternion_normalize_assert.svh
// Assertion macros used by the quaternion normalization top level.
`ifndef QUATERNION_NORMALIZE_ASSERT_SVH
`define QUATERNION_NORMALIZE_ASSERT_SVH

// Implication checked in the same cycle.
`define QN_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the following cycle.
`define QN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/qnorm_pkg.sv
// Shared constants and transaction types for quaternion normalization.
`timescale 1ns / 1ps
package qnorm_pkg;
   localparam int CB        = 16;
   localparam int FRAC      = CB - 2;
   localparam int NSTEP     = FRAC + 1;
   localparam int Q_W       = FRAC + 1;
   localparam int LEN_W     = 2 * CB + 1;
   localparam int SQ_W      = 2 * CB;
   localparam int E_W       = 4 * CB + 2;
   localparam int P_W       = 3 * CB + 2;
   localparam int SQ_SHIFT  = 2 * CB - 2;
   localparam int LANE_LAT  = NSTEP + 2;

   typedef struct packed {
      logic signed [CB-1:0] comp_w;
      logic signed [CB-1:0] comp_x;
      logic signed [CB-1:0] comp_y;
      logic signed [CB-1:0] comp_z;
   } req_type;

   typedef struct packed {
      logic signed [CB-1:0] unit_w;
      logic signed [CB-1:0] unit_x;
      logic signed [CB-1:0] unit_y;
      logic signed [CB-1:0] unit_z;
      logic [LEN_W-1:0]     length_squared;
      logic                 zero_length;
   } rsp_type;
endpackage

FILE: rtl/qnorm_lane.sv
// One component's pipelined rounded scaling by the reciprocal square root.
`timescale 1ns / 1ps
module qnorm_lane (
   input  logic                            clock,
   input  logic [qnorm_pkg::CB-1:0]        in_mag,
   input  logic                            in_neg,
   input  logic [qnorm_pkg::SQ_W-1:0]      in_sq,
   input  logic [qnorm_pkg::LEN_W-1:0]     in_len,
   input  logic                            in_zero,
   output logic signed [qnorm_pkg::CB-1:0] out_unit
);
   import qnorm_pkg::*;

   // Each stage decides one result bit. The residue e tracks
   // mag^2 * 2^(2*CB-2) - (2q-1)^2 * len and p tracks (2q-1) * len, so a
   // trial bit costs only shifted adds and a sign test.
   logic signed [E_W-1:0] e_ff [NSTEP+1];
   logic signed [P_W-1:0] p_ff [NSTEP+1];
   logic [Q_W-1:0]        q_ff [NSTEP+1];
   logic [LEN_W-1:0]      len_ff [NSTEP+1];
   logic                  neg_ff [NSTEP+1];
   logic                  zero_ff [NSTEP+1];
   logic signed [CB-1:0]  unit_ff;
   logic [CB-1:0]         mag_unused;

   assign mag_unused = in_mag;

   always_ff @(posedge clock) begin
      e_ff[0]    <= $signed(E_W'(in_sq) << SQ_SHIFT) - $signed(E_W'(in_len));
      p_ff[0]    <= -$signed(P_W'(in_len));
      q_ff[0]    <= '0;
      len_ff[0]  <= in_len;
      neg_ff[0]  <= in_neg && (mag_unused != '0);
      zero_ff[0] <= in_zero;
   end

   for (genvar k = 0; k < NSTEP; k++) begin : g_step
      localparam int B = FRAC - k;
      logic signed [E_W-1:0] delta;
      logic signed [E_W-1:0] trial;

      assign delta = (E_W'(p_ff[k]) <<< (B + 2)) + $signed(E_W'(len_ff[k]) << (2 * B + 2));
      assign trial = e_ff[k] - delta;

      always_ff @(posedge clock) begin
         if (!trial[E_W-1]) begin
            e_ff[k+1] <= trial;
            q_ff[k+1] <= q_ff[k] | (Q_W'(1) << B);
            p_ff[k+1] <= p_ff[k] + $signed(P_W'(len_ff[k]) << (B + 1));
         end else begin
            e_ff[k+1] <= e_ff[k];
            q_ff[k+1] <= q_ff[k];
            p_ff[k+1] <= p_ff[k];
         end
         len_ff[k+1]  <= len_ff[k];
         neg_ff[k+1]  <= neg_ff[k];
         zero_ff[k+1] <= zero_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (zero_ff[NSTEP]) begin
         unit_ff <= '0;
      end else if (neg_ff[NSTEP]) begin
         unit_ff <= $signed(CB'(0) - CB'(q_ff[NSTEP]));
      end else begin
         unit_ff <= $signed(CB'(q_ff[NSTEP]));
      end
   end

   assign out_unit = unit_ff;
endmodule

FILE: rtl/quaternion_normalize.sv
// Quaternion normalization: top level with the front end and four lanes.
`timescale 1ns / 1ps
// Takes one quaternion per clock cycle and returns its unit quaternion in
// Q1.14, rounded to nearest with ties away from zero, plus the squared
// length in Q5.28. busy stays low, so a transaction may start in every
// cycle. Each result appears on rsp_data with rsp_valid high for one cycle,
// after four front-end stages (input, magnitude, square, sum) and 17 lane
// stages, one per result bit of the reciprocal-root recurrence plus entry
// and output registers. An all-zero input gives zero components with
// zero_length set.
module quaternion_normalize (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  qnorm_pkg::req_type  req_data,
   output logic                rsp_valid,
   output qnorm_pkg::rsp_type  rsp_data
);
   import qnorm_pkg::*;

   `include "quaternion_normalize_assert.svh"

   req_type              req_ff;
   logic                 v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [CB-1:0] comp [4];
   logic [CB-1:0]        mag_in [4];
   logic [CB-1:0]        mag2_ff [4];
   logic                 neg2_ff [4];
   logic [CB-1:0]        mag3_ff [4];
   logic                 neg3_ff [4];
   logic [SQ_W-1:0]      sq3_ff [4];
   logic [CB-1:0]        mag4_ff [4];
   logic                 neg4_ff [4];
   logic [SQ_W-1:0]      sq4_ff [4];
   logic [LEN_W-1:0]     len_in;
   logic [LEN_W-1:0]     len4_ff;
   logic                 zero4_ff;
   logic                 vd_ff [LANE_LAT];
   logic [LEN_W-1:0]     lend_ff [LANE_LAT];
   logic                 zerod_ff [LANE_LAT];
   logic signed [CB-1:0] unit [4];

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_data;
   end

   assign comp[0] = req_ff.comp_w;
   assign comp[1] = req_ff.comp_x;
   assign comp[2] = req_ff.comp_y;
   assign comp[3] = req_ff.comp_z;

   assign len_in = LEN_W'(sq3_ff[0]) + LEN_W'(sq3_ff[1]) + LEN_W'(sq3_ff[2])
                 + LEN_W'(sq3_ff[3]);

   for (genvar i = 0; i < 4; i++) begin : g_front
      assign mag_in[i] = comp[i][CB-1] ? (~comp[i] + CB'(1)) : comp[i];

      always_ff @(posedge clock) begin
         mag2_ff[i] <= mag_in[i];
         neg2_ff[i] <= comp[i][CB-1];
         mag3_ff[i] <= mag2_ff[i];
         neg3_ff[i] <= neg2_ff[i];
         sq3_ff[i]  <= SQ_W'(mag2_ff[i]) * SQ_W'(mag2_ff[i]);
         mag4_ff[i] <= mag3_ff[i];
         neg4_ff[i] <= neg3_ff[i];
         sq4_ff[i]  <= sq3_ff[i];
      end

      qnorm_lane u_lane (
         .clock    (clock),
         .in_mag   (mag4_ff[i]),
         .in_neg   (neg4_ff[i]),
         .in_sq    (sq4_ff[i]),
         .in_len   (len4_ff),
         .in_zero  (zero4_ff),
         .out_unit (unit[i])
      );
   end

   always_ff @(posedge clock) begin
      len4_ff  <= len_in;
      zero4_ff <= (len_in == '0);
   end

   // Side line that carries valid, length and the zero flag past the lanes.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LANE_LAT; k++) begin
            vd_ff[k] <= 1'b0;
         end
      end else begin
         vd_ff[0] <= v4_ff;
         for (int k = 1; k < LANE_LAT; k++) begin
            vd_ff[k] <= vd_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      lend_ff[0]  <= len4_ff;
      zerod_ff[0] <= zero4_ff;
      for (int k = 1; k < LANE_LAT; k++) begin
         lend_ff[k]  <= lend_ff[k-1];
         zerod_ff[k] <= zerod_ff[k-1];
      end
   end

   assign rsp_valid               = vd_ff[LANE_LAT-1];
   assign rsp_data.unit_w         = unit[0];
   assign rsp_data.unit_x         = unit[1];
   assign rsp_data.unit_y         = unit[2];
   assign rsp_data.unit_z         = unit[3];
   assign rsp_data.length_squared = lend_ff[LANE_LAT-1];
   assign rsp_data.zero_length    = zerod_ff[LANE_LAT-1];

   `QN_ASSERT_NOW(a_zero_units, clock, reset, rsp_valid && rsp_data.zero_length, rsp_data.unit_w == '0 && rsp_data.unit_x == '0 && rsp_data.unit_y == '0 && rsp_data.unit_z == '0, "zero length with nonzero components")
   `QN_ASSERT_NOW(a_zero_flag, clock, reset, rsp_valid, rsp_data.zero_length == (rsp_data.length_squared == '0), "zero flag disagrees with length")
   `QN_ASSERT_NOW(a_unit_range, clock, reset, rsp_valid, rsp_data.unit_w <= $signed(CB'(1) << FRAC) && rsp_data.unit_w >= -$signed(CB'(1) << FRAC), "component out of unit range")
   `QN_ASSERT_NEXT(a_front_valid, clock, reset, start, v1_ff, "accepted transaction not captured")
endmodule

FILE: test/quaternion_normalize_checker.sv
// Checker that predicts and compares quaternion normalization results.
`timescale 1ns / 1ps
module quaternion_normalize_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  qnorm_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  qnorm_pkg::rsp_type rsp_data,
   output int                 error_count,
   output int                 pending_count
);
   import qnorm_pkg::*;

   rsp_type expected_units[$];

   // Largest q in [0, 2^FRAC] with (2q-1)^2 * len <= mag^2 * 2^(2CB-2).
   function automatic logic [CB-1:0] round_scaled(input logic [CB-1:0] mag,
                                                  input logic [LEN_W-1:0] len);
      logic [Q_W:0] q;
      logic [Q_W:0] cand;
      logic [127:0] lhs;
      logic [127:0] rhs;
      logic [Q_W+1:0] odd;
      q = '0;
      rhs = (128'(mag) * 128'(mag)) << SQ_SHIFT;
      for (int b = FRAC; b >= 0; b--) begin
         cand = q | ((Q_W+1)'(1) << b);
         if (cand <= (Q_W+1)'(1) << FRAC) begin
            odd = {cand, 1'b0} - (Q_W+2)'(1);
            lhs = 128'(odd) * 128'(odd) * 128'(len);
            if (lhs <= rhs) q = cand;
         end
      end
      return CB'(q);
   endfunction

   function automatic rsp_type normalize_quaternion(input req_type r);
      rsp_type o;
      logic [CB-1:0] comps[4];
      logic [CB-1:0] mags[4];
      logic [CB-1:0] units[4];
      logic [LEN_W-1:0] len;
      comps = '{r.comp_w, r.comp_x, r.comp_y, r.comp_z};
      len = '0;
      for (int i = 0; i < 4; i++) begin
         mags[i] = comps[i][CB-1] ? -comps[i] : comps[i];
         len += {{(LEN_W-CB){1'b0}}, mags[i]} * {{(LEN_W-CB){1'b0}}, mags[i]};
      end
      for (int i = 0; i < 4; i++) begin
         units[i] = (len == 0) ? '0 : round_scaled(mags[i], len);
         if (comps[i][CB-1]) units[i] = -units[i];
      end
      o.unit_w = units[0];
      o.unit_x = units[1];
      o.unit_y = units[2];
      o.unit_z = units[3];
      o.length_squared = len;
      o.zero_length = (len == 0);
      return o;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   always_ff @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         error_count = 0;
         expected_units.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_units.size() == 0) begin
               report_mismatch("unexpected transaction", 1, 0);
            end else begin
               want = expected_units.pop_front();
               if (rsp_data.unit_w !== want.unit_w)
                  report_mismatch("unit_w", rsp_data.unit_w, want.unit_w);
               if (rsp_data.unit_x !== want.unit_x)
                  report_mismatch("unit_x", rsp_data.unit_x, want.unit_x);
               if (rsp_data.unit_y !== want.unit_y)
                  report_mismatch("unit_y", rsp_data.unit_y, want.unit_y);
               if (rsp_data.unit_z !== want.unit_z)
                  report_mismatch("unit_z", rsp_data.unit_z, want.unit_z);
               if (rsp_data.length_squared !== want.length_squared)
                  report_mismatch("length_squared", rsp_data.length_squared,
                                  want.length_squared);
               if (rsp_data.zero_length !== want.zero_length)
                  report_mismatch("zero_length", rsp_data.zero_length, want.zero_length);
            end
         end
         if (start && !busy) expected_units.push_back(normalize_quaternion(req_data));
      end
   end

   assign pending_count = expected_units.size();
endmodule

FILE: test/testbench.sv
// Top of the quaternion normalization testbench: stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
   import qnorm_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 40;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      error_count;
   int      pending_count;
   int      cycle_count;
   int      idle_percent;

   quaternion_normalize u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   quaternion_normalize_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .error_count(error_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // Holds the transaction until it is accepted, after a random idle gap.
   // start stays high on return so that back-to-back transactions need no gap.
   task automatic send_quaternion(input req_type q);
      while ($urandom_range(99) < idle_percent) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic logic [CB-1:0] random_component();
      case ($urandom_range(5))
         0: return '0;
         1: return {1'b1, {(CB-1){1'b0}}};
         2: return {1'b0, {(CB-1){1'b1}}};
         3: return CB'($urandom_range(7)) - CB'(3);
         default: return CB'($urandom);
      endcase
   endfunction

   initial begin
      req_type q;
      logic [CB-1:0] most_neg;
      logic [CB-1:0] most_pos;
      most_neg = {1'b1, {(CB-1){1'b0}}};
      most_pos = {1'b0, {(CB-1){1'b1}}};
      cycle_count = 0;
      idle_percent = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero length, extremes, unit axes, tiny values, a rounding to zero.
      send_quaternion('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
      send_quaternion('{most_neg, most_neg, most_neg, most_neg});
      send_quaternion('{most_pos, most_pos, most_pos, most_pos});
      send_quaternion('{most_neg, 16'sd0, 16'sd0, 16'sd0});
      send_quaternion('{16'sd0, most_pos, 16'sd0, 16'sd0});
      send_quaternion('{16'sd16384, 16'sd0, 16'sd0, 16'sd0});
      send_quaternion('{16'sd0, 16'sd0, -16'sd16384, 16'sd0});
      send_quaternion('{16'sd0, 16'sd0, 16'sd0, 16'sd1});
      send_quaternion('{-16'sd1, 16'sd1, -16'sd1, 16'sd1});
      send_quaternion('{most_pos, -16'sd1, 16'sd0, 16'sd1});
      send_quaternion('{most_neg, -16'sd1, 16'sd1, most_pos});
      send_quaternion('{16'sd3, -16'sd4, 16'sd0, 16'sd0});
      send_quaternion('{16'sd8192, 16'sd8192, 16'sd8192, -16'sd8192});

      // Pause until every expected transaction has come back.
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);

      for (int phase = 0; phase < 3; phase++) begin
         idle_percent = (phase == 0) ? 34 : (phase == 1) ? 50 : 0;
         repeat (170) begin
            q.comp_w = random_component();
            q.comp_x = random_component();
            q.comp_y = random_component();
            q.comp_z = random_component();
            send_quaternion(q);
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end
endmodule
